@@ rtl/mcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared types, constants and helpers for the mip chain box downsampler.
// ----------------------------------------------------------------------------
package mcbd_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_LEVELS = 13;

  localparam int SIZE_W  = 13;
  localparam int LVL_W   = 4;
  localparam int COORD_W = 11;
  localparam int CH_W    = 8;
  localparam int SUM_W   = 9;
  localparam int NUM_CH  = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd1024;

  typedef enum logic {
    REG_BASE_WIDTH  = 1'b0,
    REG_BASE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [LVL_W-1:0]  levels;
  } cfg_t;

  // size of a level, never below one
  function automatic logic [SIZE_W-1:0] size_at(input logic [SIZE_W-1:0] s,
                                                input logic [LVL_W-1:0] l);
    logic [SIZE_W-1:0] v;
    v = s >> l;
    return (v == '0) ? SIZE_W'(1) : v;
  endfunction

endpackage

@@ rtl/mcbd_if.sv @@
// ----------------------------------------------------------------------------
// mcbd_if
// Valid/ready channels for base pixels and produced mip pixels.
// ----------------------------------------------------------------------------
interface pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  modport source(output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink(input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mip_level;
  logic [10:0] pixel_x;
  logic [10:0] pixel_y;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        run_last;
  logic        chain_done;
  modport source(output valid, mip_level, pixel_x, pixel_y, out_red, out_green,
                 out_blue, out_alpha, run_last, chain_done, input ready);
  modport sink(input valid, mip_level, pixel_x, pixel_y, out_red, out_green,
               out_blue, out_alpha, run_last, chain_done, output ready);
endinterface

@@ rtl/mip_chain_box_downsampler.sv @@
// ----------------------------------------------------------------------------
// mip_chain_box_downsampler
// Streams base RGBA8 pixels and emits every lower mip level (2x2 rounded box).
// ----------------------------------------------------------------------------
// a result is registered in the b stage and then the o stage after its item
// throughput: one item per cycle unless the output stalls; each result feeding
//   a further level takes an input slot, set by the shared line memory port
// reset: sizes 1024 x 1024, level counters cleared; line memory is not cleared
// a size register write restarts the frame
module mip_chain_box_downsampler #(
  parameter int MAX_WIDTH  = mcbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVELS = mcbd_pkg::DEF_MAX_LEVELS
) (
  input  logic                        clk,
  input  logic                        rst,
  pix_if.sink                         pix,
  res_if.source                       res,
  input  logic                        cfg_we,
  input  mcbd_pkg::reg_idx_t          cfg_index,
  input  logic [mcbd_pkg::SIZE_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = CW - 1;
  localparam int NF = MAX_LEVELS - 1;
  localparam int LW = (NF > 1) ? $clog2(NF) : 1;
  localparam int PW = mcbd_pkg::NUM_CH * mcbd_pkg::SUM_W;
  localparam int XW = mcbd_pkg::NUM_CH * mcbd_pkg::CH_W;
  localparam logic [CW:0] MW = (CW + 1)'(MAX_WIDTH);

  mcbd_pkg::cfg_t cfg;

  mcbd_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_LEVELS(MAX_LEVELS)) u_cfg (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cfg(cfg)
  );

  logic [CW-1:0] col [NF];
  logic [CW-1:0] row [NF];
  logic [XW-1:0] held [NF];
  logic [PW-1:0] lines [MAX_WIDTH];
  logic [PW-1:0] rdata;

  logic                          b_valid, b_cas, b_h1, b_done;
  logic [mcbd_pkg::LVL_W-1:0]    b_lv;
  logic [mcbd_pkg::COORD_W-1:0]  b_x, b_y;
  logic [PW-1:0]                 b_pair;
  logic [XW-1:0]                 b_res;
  logic                          b_free, out_free;

  logic                          o_valid, o_last, o_done;
  logic [mcbd_pkg::LVL_W-1:0]    o_lv;
  logic [mcbd_pkg::COORD_W-1:0]  o_x, o_y;
  logic [XW-1:0]                 o_px;

  logic                          a_cas, a_fire, a_act;
  logic [mcbd_pkg::LVL_W-1:0]    a_lv, a_nlv;
  logic [LW-1:0]                 idx;
  logic [XW-1:0]                 a_px, held_px;
  logic [CW-1:0]                 x, y;
  logic [mcbd_pkg::SIZE_W-1:0]   w, h, nw, nh;
  logic                          w1, h1, last_col, last_row;
  logic                          have, emit, line_we, line_re, held_we, a_casn, a_done;
  logic [PW-1:0]                 pair;
  logic [HW-1:0]                 hx, dy;
  logic [CW:0]                   off;
  logic [CW-1:0]                 addr;

  assign out_free = !o_valid || res.ready;
  assign b_free   = !b_valid || out_free;

  always_comb begin
    a_cas  = b_valid && b_cas;
    a_lv   = a_cas ? b_lv : '0;
    a_px   = a_cas ? b_res : {pix.in_alpha, pix.in_blue, pix.in_green, pix.in_red};
    a_fire = b_free && (a_cas || pix.valid);
    a_act  = a_fire && (cfg.levels != mcbd_pkg::LVL_W'(1));
    idx    = a_lv[LW-1:0];
    x      = col[idx];
    y      = row[idx];
    held_px = held[idx];
    w      = mcbd_pkg::size_at(cfg.width, a_lv);
    h      = mcbd_pkg::size_at(cfg.height, a_lv);
    a_nlv  = a_lv + mcbd_pkg::LVL_W'(1);
    nw     = mcbd_pkg::size_at(cfg.width, a_nlv);
    nh     = mcbd_pkg::size_at(cfg.height, a_nlv);
    w1     = (w == mcbd_pkg::SIZE_W'(1));
    h1     = (h == mcbd_pkg::SIZE_W'(1));
    last_col = (mcbd_pkg::SIZE_W'(x) == w - mcbd_pkg::SIZE_W'(1));
    last_row = (mcbd_pkg::SIZE_W'(y) == h - mcbd_pkg::SIZE_W'(1));
    for (int c = 0; c < mcbd_pkg::NUM_CH; c++) begin
      if (w1) begin
        pair[c*9 +: 9] = {a_px[c*8 +: 8], 1'b0};
      end else begin
        pair[c*9 +: 9] = {1'b0, held_px[c*8 +: 8]} + {1'b0, a_px[c*8 +: 8]};
      end
    end
    hx      = x[CW-1:1];
    dy      = y[CW-1:1];
    have    = w1 || x[0];
    emit    = have && (h1 || y[0]);
    held_we = a_act && !w1 && !x[0] && !last_col;
    line_we = a_act && have && !h1 && !y[0] && !last_row;
    line_re = a_act && emit && !h1;
    off     = MW - (MW >> a_lv);
    addr    = off[CW-1:0] + CW'(hx);
    a_casn  = ({1'b0, a_nlv} + 5'd1) < {1'b0, cfg.levels};
    a_done  = ({1'b0, a_nlv} + 5'd1) == {1'b0, cfg.levels}
              && (mcbd_pkg::SIZE_W'(hx) + mcbd_pkg::SIZE_W'(1) == nw)
              && (mcbd_pkg::SIZE_W'(dy) + mcbd_pkg::SIZE_W'(1) == nh);
  end

  always_comb begin
    logic [9:0] tot;
    logic [9:0] rnd;
    for (int c = 0; c < mcbd_pkg::NUM_CH; c++) begin
      tot = b_h1 ? {b_pair[c*9 +: 9], 1'b0}
                 : {1'b0, rdata[c*9 +: 9]} + {1'b0, b_pair[c*9 +: 9]};
      rnd = tot + 10'd2;
      b_res[c*8 +: 8] = rnd[9:2];
    end
  end

  assign pix.ready = b_free && !a_cas;

  // line memory of horizontal pair sums, one region per level
  always_ff @(posedge clk) begin
    if (line_we) lines[addr] <= pair;
    if (line_re) rdata <= lines[addr];
    if (held_we) held[idx] <= a_px;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int i = 0; i < NF; i++) begin
        col[i] <= '0;
        row[i] <= '0;
      end
    end else if (a_act) begin
      if (last_col) begin
        col[idx] <= '0;
        row[idx] <= last_row ? '0 : y + CW'(1);
      end else begin
        col[idx] <= x + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_act && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free) begin
      b_cas  <= a_casn;
      b_h1   <= h1;
      b_done <= a_done;
      b_lv   <= a_nlv;
      b_x    <= mcbd_pkg::COORD_W'(hx);
      b_y    <= mcbd_pkg::COORD_W'(dy);
      b_pair <= pair;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (out_free) begin
      o_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && b_valid) begin
      o_lv   <= b_lv;
      o_x    <= b_x;
      o_y    <= b_y;
      o_px   <= b_res;
      o_done <= b_done;
      o_last <= !(b_cas && emit);
    end
  end

  assign res.valid      = o_valid;
  assign res.mip_level  = o_lv;
  assign res.pixel_x    = o_x;
  assign res.pixel_y    = o_y;
  assign res.out_red    = o_px[7:0];
  assign res.out_green  = o_px[15:8];
  assign res.out_blue   = o_px[23:16];
  assign res.out_alpha  = o_px[31:24];
  assign res.run_last   = o_last;
  assign res.chain_done = o_done;

endmodule

@@ rtl/mcbd_cfg.sv @@
// ----------------------------------------------------------------------------
// mcbd_cfg
// Size registers with clamping and level count derivation.
// ----------------------------------------------------------------------------
module mcbd_cfg #(
  parameter int MAX_WIDTH  = mcbd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVELS = mcbd_pkg::DEF_MAX_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  mcbd_pkg::reg_idx_t              cfg_index,
  input  logic [mcbd_pkg::SIZE_W-1:0]     cfg_data,
  output mcbd_pkg::cfg_t                  cfg
);

  logic [mcbd_pkg::SIZE_W-1:0] width;
  logic [mcbd_pkg::SIZE_W-1:0] height;
  logic [mcbd_pkg::SIZE_W-1:0] clamped;
  logic [mcbd_pkg::SIZE_W-1:0] larger;
  logic [mcbd_pkg::LVL_W-1:0]  msb;

  always_comb begin
    if (cfg_data == '0) begin
      clamped = mcbd_pkg::SIZE_W'(1);
    end else if (int'(cfg_data) > MAX_WIDTH) begin
      clamped = mcbd_pkg::SIZE_W'(MAX_WIDTH);
    end else begin
      clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= mcbd_pkg::SIZE_RESET;
      height <= mcbd_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mcbd_pkg::REG_BASE_WIDTH:  width  <= clamped;
        mcbd_pkg::REG_BASE_HEIGHT: height <= clamped;
        default: ;
      endcase
    end
  end

  // levels = floor(log2(max)) + 1 by highest set bit, capped at MAX_LEVELS
  always_comb begin
    larger = (width > height) ? width : height;
    msb = '0;
    for (int i = 1; i < mcbd_pkg::SIZE_W; i++) begin
      if (larger[i]) msb = mcbd_pkg::LVL_W'(i);
    end
    cfg.width  = width;
    cfg.height = height;
    if (int'(msb) + 1 > MAX_LEVELS) begin
      cfg.levels = mcbd_pkg::LVL_W'(MAX_LEVELS);
    end else begin
      cfg.levels = msb + mcbd_pkg::LVL_W'(1);
    end
  end

endmodule

@@ rtl/mcbd_checker.sv @@
// ----------------------------------------------------------------------------
// mcbd_checker
// Port-level checks on the result channel of the mip chain downsampler.
// ----------------------------------------------------------------------------
module mcbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [3:0] mip_level,
  input logic       run_last,
  input logic       chain_done
);

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  a_level_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> mip_level != 4'd0)
    else $error("result at base level");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && chain_done |-> run_last)
    else $error("final pixel not last of its item");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

endmodule

bind mip_chain_box_downsampler mcbd_checker u_mcbd_checker (
  .clk(clk), .rst(rst), .res_valid(res.valid), .res_ready(res.ready),
  .mip_level(res.mip_level), .run_last(res.run_last), .chain_done(res.chain_done)
);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Bench for the mip chain box downsampler. Streams base pixel frames of many
// sizes (including clamped and degenerate ones) with random gaps and stalls,
// predicts every mip level pixel in software, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] r, g, b, a;
  } pix_t;

  typedef struct packed {
    logic [3:0]  lvl;
    logic [10:0] x, y;
    logic [7:0]  r, g, b, a;
    logic        last, done;
  } mip_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  mcbd_pkg::reg_idx_t cfg_index = mcbd_pkg::REG_BASE_WIDTH;
  logic [mcbd_pkg::SIZE_W-1:0] cfg_data = '0;

  pix_if pix();
  res_if res();

  mip_chain_box_downsampler u_top (
    .clk(clk), .rst(rst), .pix(pix), .res(res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pix_t pixel_q[$];
  mip_t mip_q[$];
  int errors = 0;
  int sent = 0;
  bit no_idle = 0;
  bit src_hold = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int quiet = 0;

  // predicted block state
  int unsigned bw, bh, lvl_cnt;
  int unsigned lw[13], lh[13], col[13], row[13];
  logic [31:0] held[13];
  logic [35:0] pair_lines[13][2048];

  function automatic int unsigned clamp_size(input logic [12:0] v);
    if (v == 0) return 1;
    if (v > 4096) return 4096;
    return v;
  endfunction

  function automatic void add_pixel(input pix_t p);
    pixel_q = {pixel_q, p};
  endfunction

  task automatic restart_frame();
    int unsigned m, n;
    m = (bw > bh) ? bw : bh;
    n = 1;
    while (m > 1) begin
      m = m >> 1;
      n++;
    end
    lvl_cnt = (n > 13) ? 13 : n;
    lw[0] = bw;
    lh[0] = bh;
    for (int i = 1; i < 13; i++) begin
      lw[i] = (lw[i-1] / 2 > 0) ? lw[i-1] / 2 : 1;
      lh[i] = (lh[i-1] / 2 > 0) ? lh[i-1] / 2 : 1;
    end
    for (int i = 0; i < 13; i++) begin
      col[i] = 0;
      row[i] = 0;
      held[i] = '0;
    end
  endtask

  task automatic predict_mips(input pix_t p);
    int unsigned px[4], pr[4], tot[4];
    int unsigned x, y, w, h, hx, dy, n;
    bit have, emit;
    mip_t m;
    px[0] = p.r; px[1] = p.g; px[2] = p.b; px[3] = p.a;
    n = 0;
    for (int lv = 0; lv + 1 < lvl_cnt; lv++) begin
      x = col[lv]; y = row[lv]; w = lw[lv]; h = lh[lv];
      hx = 0; dy = 0; have = 0; emit = 0;
      if (x + 1 >= w) begin
        col[lv] = 0;
        row[lv] = (y + 1 >= h) ? 0 : y + 1;
      end else col[lv] = x + 1;
      if (w == 1) begin
        for (int c = 0; c < 4; c++) pr[c] = 2 * px[c];
        have = 1;
      end else if (x[0] == 1'b0) begin
        if (x + 1 < w) held[lv] = {px[3][7:0], px[2][7:0], px[1][7:0], px[0][7:0]};
      end else begin
        for (int c = 0; c < 4; c++) pr[c] = held[lv][8*c +: 8] + px[c];
        hx = x >> 1;
        have = 1;
      end
      if (!have || hx >= 2048) break;
      if (h == 1) begin
        for (int c = 0; c < 4; c++) tot[c] = 2 * pr[c];
        emit = 1;
      end else if (y[0] == 1'b0) begin
        if (y + 1 < h)
          for (int c = 0; c < 4; c++) pair_lines[lv][hx][9*c +: 9] = pr[c][8:0];
      end else begin
        for (int c = 0; c < 4; c++) tot[c] = pair_lines[lv][hx][9*c +: 9] + pr[c];
        dy = y >> 1;
        emit = 1;
      end
      if (!emit) break;
      for (int c = 0; c < 4; c++) px[c] = ((tot[c] + 2) >> 2) & 8'hff;
      m.lvl = 4'(lv + 1); m.x = 11'(hx); m.y = 11'(dy);
      m.r = 8'(px[0]); m.g = 8'(px[1]); m.b = 8'(px[2]); m.a = 8'(px[3]);
      m.last = 1'b0;
      m.done = (lv + 2 == lvl_cnt && hx + 1 == lw[lv+1] && dy + 1 == lh[lv+1]);
      mip_q = {mip_q, m};
      n++;
    end
    if (n > 0) mip_q[mip_q.size()-1].last = 1'b1;
  endtask

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("error %0s: got %0d want %0d", what, got, want);
  endtask

  // driver
  int src_gap = 0;
  always @(posedge clk) begin
    bit nv;
    pix_t nxt;
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      nv = pix.valid;
      if (pix.valid && pix.ready) begin
        predict_mips(pixel_q.pop_front());
        sent++;
        nv = 0;
        src_gap = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (!nv) begin
        if (src_gap > 0) src_gap--;
        else if (pixel_q.size() > 0 && !src_hold) begin
          nv = 1;
          nxt = pixel_q[0];
          pix.in_red <= nxt.r;
          pix.in_green <= nxt.g;
          pix.in_blue <= nxt.b;
          pix.in_alpha <= nxt.a;
        end
      end
      pix.valid <= nv;
    end
  end

  // monitor
  int snk_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    mip_t e;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (mip_q.size() == 0) report("unexpected item level", res.mip_level, 0);
        else begin
          e = mip_q.pop_front();
          if (res.mip_level !== e.lvl) report("mip_level", res.mip_level, e.lvl);
          if (res.pixel_x !== e.x) report("pixel_x", res.pixel_x, e.x);
          if (res.pixel_y !== e.y) report("pixel_y", res.pixel_y, e.y);
          if (res.out_red !== e.r) report("out_red", res.out_red, e.r);
          if (res.out_green !== e.g) report("out_green", res.out_green, e.g);
          if (res.out_blue !== e.b) report("out_blue", res.out_blue, e.b);
          if (res.out_alpha !== e.a) report("out_alpha", res.out_alpha, e.a);
          if (res.run_last !== e.last) report("run_last", res.run_last, e.last);
          if (res.chain_done !== e.done) report("chain_done", res.chain_done, e.done);
        end
        snk_gap = no_idle ? 0 : $urandom_range(0, 3);
      end else if (snk_gap > 0) snk_gap--;
      if (stall_seen < stall_req) begin
        stall_seen++;
        hold_left = 300;
      end else if (hold_left > 0) hold_left--;
      res.ready <= (snk_gap == 0 && hold_left == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() > 0 || pix.valid || mip_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_size(input logic [12:0] w, input logic [12:0] h);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mcbd_pkg::REG_BASE_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= mcbd_pkg::REG_BASE_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    bw = clamp_size(w);
    bh = clamp_size(h);
    restart_frame();
  endtask

  function automatic pix_t rand_pix();
    pix_t p;
    p = $urandom;
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = '1;
      default: ;
    endcase
    return p;
  endfunction

  task automatic push_pixels(input int n);
    for (int i = 0; i < n; i++) add_pixel(rand_pix());
  endtask

  initial begin
    int w, h;
    pix.valid = 1'b0;
    pix.in_red = '0;
    pix.in_green = '0;
    pix.in_blue = '0;
    pix.in_alpha = '0;
    res.ready = 1'b0;
    bw = 1024;
    bh = 1024;
    restart_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // reset size, first row only
    push_pixels(6);
    // 2x2 extremes
    set_size(2, 2);
    add_pixel('1);
    add_pixel('1);
    add_pixel('0);
    add_pixel('1);
    set_size(3, 3);
    push_pixels(9);
    set_size(1, 1);
    push_pixels(3);
    set_size(8191, 0);
    push_pixels(12);
    set_size(0, 4096);
    push_pixels(8);
    // long sink stall with the source still offering
    set_size(8, 8);
    stall_req++;
    push_pixels(64);
    wait_idle();
    // source pause mid frame
    set_size(4, 4);
    push_pixels(8);
    wait_idle();
    push_pixels(8);
    while (sent < 205) begin
      w = $urandom_range(1, 9);
      h = $urandom_range(1, 9);
      no_idle = ($urandom_range(0, 3) == 0);
      set_size(13'(w), 13'(h));
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < w * h; i++) add_pixel($urandom);
      end else push_pixels(w * h * (1 + $urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) push_pixels($urandom_range(1, 5));
    end
    no_idle = 0;
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0 && mip_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mcbd_pkg.sv
rtl/mcbd_if.sv
rtl/mcbd_cfg.sv
rtl/mip_chain_box_downsampler.sv
rtl/mcbd_checker.sv
bench/tb_top.sv
